// ----- src/asmd_pkg.sv -----
`timescale 1ns / 1ps

package asmd_pkg;

  localparam int LEVEL_W = 16;
  localparam int AXIS_W  = 16;
  localparam int MAG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int TOTAL_W = 32;
  localparam int CLASS_W = 2;

  // Item kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_STEP_HIGH = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEP_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WALKING   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RUNNING   = 3'd3;
  localparam logic [IDX_W-1:0] REG_FALL      = 3'd4;

  // Motion classes
  localparam logic [CLASS_W-1:0] CLASS_STILL   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_WALKING = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_RUNNING = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_FALL    = 2'd3;

  localparam int RST_STEP_HIGH = 614;
  localparam int RST_STEP_LOW  = 461;
  localparam int RST_WALKING   = 538;
  localparam int RST_RUNNING   = 717;
  localparam int RST_FALL      = 1280;

  typedef logic [MAG_W-1:0] mag_t;

  // Thresholds are held squared so that the magnitude never needs a root.
  localparam mag_t SQ_RST_STEP_HIGH = mag_t'(RST_STEP_HIGH * RST_STEP_HIGH);
  localparam mag_t SQ_RST_STEP_LOW  = mag_t'(RST_STEP_LOW * RST_STEP_LOW);
  localparam mag_t SQ_RST_WALKING   = mag_t'(RST_WALKING * RST_WALKING);
  localparam mag_t SQ_RST_RUNNING   = mag_t'(RST_RUNNING * RST_RUNNING);
  localparam mag_t SQ_RST_FALL      = mag_t'(RST_FALL * RST_FALL);

  typedef struct packed {
    mag_t step_high;
    mag_t step_low;
    mag_t walking;
    mag_t running;
    mag_t fall;
  } levels_t;

  typedef struct packed {
    logic op;
    mag_t mag;
  } mag_item_t;

endpackage

// ----- src/asmd_in_if.sv -----
`timescale 1ns / 1ps

interface asmd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [asmd_pkg::AXIS_W-1:0]  accel_x;
  logic signed [asmd_pkg::AXIS_W-1:0]  accel_y;
  logic signed [asmd_pkg::AXIS_W-1:0]  accel_z;

  modport source (output valid, output op, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input op, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

// ----- src/asmd_out_if.sv -----
`timescale 1ns / 1ps

interface asmd_out_if;
  logic                                valid;
  logic                                ready;
  logic [asmd_pkg::TOTAL_W-1:0]        step_total;
  logic [asmd_pkg::CLASS_W-1:0]        motion_class;
  logic                                step_seen;
  logic                                save_due;
  logic                                fall_pending;

  modport source (output valid, output step_total, output motion_class, output step_seen,
                  output save_due, output fall_pending, input ready);
  modport sink (input valid, input step_total, input motion_class, input step_seen,
                input save_due, input fall_pending, output ready);
endinterface

// ----- src/asmd_levels.sv -----
`timescale 1ns / 1ps

module asmd_levels (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [asmd_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [asmd_pkg::LEVEL_W-1:0] cfg_data,
  output asmd_pkg::levels_t            levels
);

  asmd_pkg::levels_t levels_r;
  asmd_pkg::levels_t levels_nxt;
  asmd_pkg::mag_t    sq_data;

  // The square is taken once on the write, not on every sample.
  assign sq_data = asmd_pkg::mag_t'(cfg_data) * asmd_pkg::mag_t'(cfg_data);

  always_comb begin
    levels_nxt = levels_r;
    if (cfg_we) begin
      case (cfg_idx)
        asmd_pkg::REG_STEP_HIGH: levels_nxt.step_high = sq_data;
        asmd_pkg::REG_STEP_LOW:  levels_nxt.step_low  = sq_data;
        asmd_pkg::REG_WALKING:   levels_nxt.walking   = sq_data;
        asmd_pkg::REG_RUNNING:   levels_nxt.running   = sq_data;
        asmd_pkg::REG_FALL:      levels_nxt.fall      = sq_data;
        default:                 levels_nxt = levels_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r.step_high <= asmd_pkg::SQ_RST_STEP_HIGH;
      levels_r.step_low  <= asmd_pkg::SQ_RST_STEP_LOW;
      levels_r.walking   <= asmd_pkg::SQ_RST_WALKING;
      levels_r.running   <= asmd_pkg::SQ_RST_RUNNING;
      levels_r.fall      <= asmd_pkg::SQ_RST_FALL;
    end else begin
      levels_r <= levels_nxt;
    end
  end

  assign levels = levels_r;

endmodule

// ----- src/asmd_front.sv -----
`timescale 1ns / 1ps

module asmd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  asmd_in_if.sink               in_ch,
  output logic                  mag_valid,
  output asmd_pkg::mag_item_t   mag_item,
  input  logic                  mag_ready
);

  logic                                 in_valid_r;
  logic                                 in_op_r;
  logic signed [asmd_pkg::AXIS_W-1:0]   x_r;
  logic signed [asmd_pkg::AXIS_W-1:0]   y_r;
  logic signed [asmd_pkg::AXIS_W-1:0]   z_r;
  logic                                 mag_valid_r;
  asmd_pkg::mag_item_t                  mag_item_r;
  asmd_pkg::mag_item_t                  mag_item_nxt;
  logic signed [2*asmd_pkg::AXIS_W-1:0] sq_x;
  logic signed [2*asmd_pkg::AXIS_W-1:0] sq_y;
  logic signed [2*asmd_pkg::AXIS_W-1:0] sq_z;
  logic                                 mag_slot_free;
  logic                                 in_slot_free;

  assign mag_slot_free = !mag_valid_r || mag_ready;
  assign in_slot_free  = !in_valid_r || mag_slot_free;
  assign in_ch.ready   = in_slot_free;

  // Each square is non-negative and at most 2^30, so the sum fits in 32 bits.
  assign sq_x = x_r * x_r;
  assign sq_y = y_r * y_r;
  assign sq_z = z_r * z_r;

  always_comb begin
    mag_item_nxt.op  = in_op_r;
    mag_item_nxt.mag = asmd_pkg::mag_t'(sq_x) + asmd_pkg::mag_t'(sq_y)
                     + asmd_pkg::mag_t'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mag_valid_r <= 1'b0;
    end else begin
      if (in_slot_free) in_valid_r <= in_ch.valid;
      if (mag_slot_free) mag_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_slot_free && in_ch.valid) begin
      in_op_r <= in_ch.op;
      x_r     <= in_ch.accel_x;
      y_r     <= in_ch.accel_y;
      z_r     <= in_ch.accel_z;
    end
    if (mag_slot_free && in_valid_r) mag_item_r <= mag_item_nxt;
  end

  assign mag_valid = mag_valid_r;
  assign mag_item  = mag_item_r;

endmodule

// ----- src/asmd_track.sv -----
`timescale 1ns / 1ps

module asmd_track #(
  parameter int SAVE_EVERY = 5,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mag_valid,
  input  asmd_pkg::mag_item_t mag_item,
  output logic                mag_ready,
  input  asmd_pkg::levels_t   levels,
  asmd_out_if.source          out_ch
);

  localparam int MOD_W = $clog2(SAVE_EVERY + 1);

  logic                            armed_r, armed_nxt;
  logic [COUNT_BITS-1:0]           count_r, count_nxt;
  logic [MOD_W-1:0]                mod_r, mod_nxt;
  logic                            fall_r, fall_nxt;
  logic [MOD_W-1:0]                mod_inc;
  logic                            fire;

  logic                            out_valid_r;
  logic [asmd_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic [asmd_pkg::CLASS_W-1:0]    class_r, class_nxt;
  logic                            seen_r, seen_nxt;
  logic                            save_r, save_nxt;
  logic                            pend_r, pend_nxt;

  assign mag_ready = !out_valid_r || out_ch.ready;
  assign fire      = mag_valid && mag_ready;
  assign mod_inc   = mod_r + MOD_W'(1);

  always_comb begin
    armed_nxt = armed_r;
    count_nxt = count_r;
    mod_nxt   = mod_r;
    fall_nxt  = fall_r;
    class_nxt = asmd_pkg::CLASS_STILL;
    seen_nxt  = 1'b0;
    save_nxt  = 1'b0;
    if (mag_item.op == asmd_pkg::OP_CHECK) begin
      pend_nxt = fall_r;
      fall_nxt = 1'b0;
    end else begin
      if (!armed_r && mag_item.mag > levels.step_high) begin
        armed_nxt = 1'b1;
      end else if (armed_r && mag_item.mag < levels.step_low) begin
        armed_nxt = 1'b0;
        count_nxt = count_r + COUNT_BITS'(1);
        seen_nxt  = 1'b1;
        if (mod_inc >= MOD_W'(SAVE_EVERY)) begin
          mod_nxt  = '0;
          save_nxt = 1'b1;
        end else begin
          mod_nxt = mod_inc;
        end
      end
      // Fall wins over running, running over walking, whatever the level order.
      if (mag_item.mag > levels.fall) class_nxt = asmd_pkg::CLASS_FALL;
      else if (mag_item.mag > levels.running) class_nxt = asmd_pkg::CLASS_RUNNING;
      else if (mag_item.mag > levels.walking) class_nxt = asmd_pkg::CLASS_WALKING;
      if (class_nxt == asmd_pkg::CLASS_FALL) fall_nxt = 1'b1;
      pend_nxt = fall_nxt;
    end
    total_nxt = asmd_pkg::TOTAL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      count_r     <= '0;
      mod_r       <= '0;
      fall_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mag_ready) out_valid_r <= mag_valid;
      if (fire) begin
        armed_r <= armed_nxt;
        count_r <= count_nxt;
        mod_r   <= mod_nxt;
        fall_r  <= fall_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      total_r <= total_nxt;
      class_r <= class_nxt;
      seen_r  <= seen_nxt;
      save_r  <= save_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.step_total   = total_r;
  assign out_ch.motion_class = class_r;
  assign out_ch.step_seen    = seen_r;
  assign out_ch.save_due     = save_r;
  assign out_ch.fall_pending = pend_r;

endmodule

// ----- src/accel_step_and_motion_detector.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_ch     sink       op, accel_x, accel_y, accel_z
// out_ch    source     step_total, motion_class, step_seen, save_due, fall_pending
// cfg_*     write      cfg_idx selects one of five levels, cfg_data is the level
//
// One item per cycle while out_ch is not stalled. An accepted item passes
// through the input register and the magnitude register into the result
// register, which drives out_ch. Levels are squared on the write, so a write
// takes effect for the next item that reaches the result stage.
// Synchronous active-low reset clears the step state and the fall flag and
// restores the default levels. Each stage holds while the stage after it is
// full and stalled, so input stalls only when all three registers are full.

module accel_step_and_motion_detector #(
  parameter int SAVE_EVERY = 5,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  asmd_in_if.sink                      in_ch,
  asmd_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [asmd_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [asmd_pkg::LEVEL_W-1:0] cfg_data
);

  asmd_pkg::levels_t   levels;
  logic                mag_valid;
  logic                mag_ready;
  asmd_pkg::mag_item_t mag_item;

  asmd_levels u_levels (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .levels   (levels)
  );

  asmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mag_valid (mag_valid),
    .mag_item  (mag_item),
    .mag_ready (mag_ready)
  );

  asmd_track #(
    .SAVE_EVERY (SAVE_EVERY),
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .mag_valid (mag_valid),
    .mag_item  (mag_item),
    .mag_ready (mag_ready),
    .levels    (levels),
    .out_ch    (out_ch)
  );

  // A save marker only ever comes with a completed step.
  a_save_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.save_due |-> out_ch.step_seen)
    else $error("save_due without step_seen");

  // A sample classed as a fall always reports the latched flag.
  a_fall_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.motion_class == asmd_pkg::CLASS_FALL |-> out_ch.fall_pending)
    else $error("fall class without fall_pending");

  // Input may only stall when every stage is full behind a stalled result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready && mag_valid)
    else $error("input stalled with room in the pipeline");

  // A completed step disarms the peak, so the result that follows it cannot
  // complete a step as well.
  a_no_double_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.step_seen |=>
      !(out_ch.valid && out_ch.step_seen))
    else $error("step counted twice without re-arming");

endmodule
